/* hw/rtl/ffha_pkg.sv */
// Shared constants, command types and a helper function of the heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int NFREE  = 64;
  localparam int NUSED  = 64;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int OFF_W  = 16;
  localparam int SZ_W   = 17;

  localparam logic [SZ_W-1:0] HDR_BYTES    = 17'd8;
  localparam logic [SZ_W-1:0] TWO_HDR      = 17'd16;
  localparam logic [SZ_W-1:0] ALIGN_MASK   = 17'd3;
  localparam logic [SZ_W-1:0] HEAP_CAP     = 17'd65536;

  // Operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Free row commands
  typedef enum logic [1:0] {
    F_HOLD,
    F_WRITE,
    F_INSERT,
    F_REMOVE
  } fop_t;

  typedef struct packed {
    fop_t              op;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  start;
    logic [SZ_W-1:0]   size;
  } fcmd_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  start;
    logic [SZ_W-1:0]   size;
  } ucmd_t;

  // Index of the lowest set bit, NFREE when none is set
  function automatic logic [CNT_W-1:0] first_set(input logic [NFREE-1:0] v);
    logic [CNT_W-1:0] r;
    r = CNT_W'(NFREE);
    for (int i = NFREE - 1; i >= 0; i--) begin
      if (v[i]) r = CNT_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffha_intf.sv */
// Handshake channel interfaces of the heap allocator: request, result and configuration.
`default_nettype none
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] request_bytes;
  logic [15:0] data_offset;
  modport source (output valid, op, request_bytes, data_offset, input ready);
  modport sink   (input valid, op, request_bytes, data_offset, output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] result_offset;
  logic        move_needed;
  logic [15:0] move_source;
  logic [15:0] move_length;
  logic [16:0] free_bytes;
  modport source (output valid, status, result_offset, move_needed, move_source,
                  move_length, free_bytes, input ready);
  modport sink   (input valid, status, result_offset, move_needed, move_source,
                  move_length, free_bytes, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] heap_bytes;
  modport source (output valid, heap_bytes, input ready);
  modport sink   (input valid, heap_bytes, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ffha_free_cell.sv */
// One cell of the address-ordered free extent row: holds one extent, shifts with its neighbours.
`default_nettype none
module ffha_free_cell (
  input  wire logic                          clk,
  input  wire logic [ffha_pkg::IDX_W-1:0]    cell_idx,
  input  wire ffha_pkg::fcmd_t               cmd,
  input  wire logic [ffha_pkg::OFF_W-1:0]    left_start,
  input  wire logic [ffha_pkg::SZ_W-1:0]     left_size,
  input  wire logic [ffha_pkg::OFF_W-1:0]    right_start,
  input  wire logic [ffha_pkg::SZ_W-1:0]     right_size,
  input  wire logic [ffha_pkg::OFF_W-1:0]    key_addr,
  input  wire logic [ffha_pkg::SZ_W-1:0]     key_size,
  output logic [ffha_pkg::OFF_W-1:0]         start,
  output logic [ffha_pkg::SZ_W-1:0]          size,
  output logic                               fit,
  output logic                               le
);

  logic [ffha_pkg::OFF_W-1:0] start_r;
  logic [ffha_pkg::SZ_W-1:0]  size_r;

  // Load, take from the left on insert, take from the right on remove
  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::F_WRITE: begin
        if (cmd.idx == cell_idx) begin
          start_r <= cmd.start;
          size_r  <= cmd.size;
        end
      end
      ffha_pkg::F_INSERT: begin
        if (cmd.idx == cell_idx) begin
          start_r <= cmd.start;
          size_r  <= cmd.size;
        end else if (cell_idx > cmd.idx) begin
          start_r <= left_start;
          size_r  <= left_size;
        end
      end
      ffha_pkg::F_REMOVE: begin
        if (cell_idx >= cmd.idx) begin
          start_r <= right_start;
          size_r  <= right_size;
        end
      end
      default: ;
    endcase
  end

  // Compare own extent against the broadcast keys
  assign start = start_r;
  assign size  = size_r;
  assign fit   = size_r >= key_size;
  assign le    = start_r <= key_addr;

endmodule
`default_nettype wire

/* hw/rtl/ffha_used_cell.sv */
// One cell of the allocated extent row: holds one extent and matches its data offset.
`default_nettype none
module ffha_used_cell (
  input  wire logic                          clk,
  input  wire logic [ffha_pkg::IDX_W-1:0]    cell_idx,
  input  wire ffha_pkg::ucmd_t               cmd,
  input  wire logic [ffha_pkg::OFF_W-1:0]    key_off,
  output logic [ffha_pkg::OFF_W-1:0]         start,
  output logic [ffha_pkg::SZ_W-1:0]          size,
  output logic                               match
);

  logic [ffha_pkg::OFF_W-1:0] start_r;
  logic [ffha_pkg::SZ_W-1:0]  size_r;

  // Load when addressed
  always_ff @(posedge clk) begin
    if (cmd.we && cmd.idx == cell_idx) begin
      start_r <= cmd.start;
      size_r  <= cmd.size;
    end
  end

  // Data offset is the extent start plus one header
  assign start = start_r;
  assign size  = size_r;
  assign match = (ffha_pkg::SZ_W'(start_r) + ffha_pkg::HDR_BYTES) == ffha_pkg::SZ_W'(key_off);

endmodule
`default_nettype wire

/* hw/rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer over the free and allocated cell rows.
//
// The block keeps heap metadata only: up to 64 free extents in address order and up to 64
// allocated extents, each in a row of register cells. One request is worked at a time; the
// sequencer steps through its states and every step does a broadcast search, a registered
// read of a cell or a row update. After the work, the result is handed over in S_DONE and the
// next request is taken in S_IDLE; the next request is taken while a result still waits.
// Writing heap_bytes (while idle) re-initialises the tables in S_INIT, and after reset the
// same initialisation runs before the first request.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ffha_in_if.sink      in_ch,
  ffha_out_if.source   out_ch,
  ffha_cfg_if.sink     cfg_ch
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_FIND, S_URD_A, S_URD_B, S_NB_A, S_NB_B, S_NB_C,
    S_INS_P, S_INS_D, S_INS_E, S_FREE_FIN, S_FREE_MV, S_RA_P, S_RA_D, S_RA_M2,
    S_RA_M3, S_RA_M4, S_SHR_FIN, S_TAKE_F, S_TAKE_A, S_TAKE_B, S_FRESH_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {K_ALLOC, K_FREE, K_REALLOC} kind_t;

  localparam int NF = ffha_pkg::NFREE;
  localparam int NU = ffha_pkg::NUSED;

  state_t state_r, nb_ret_r, ins_ret_r;
  kind_t  kind_r;

  logic [ffha_pkg::OFF_W-1:0] req_r, off_r, bstart_r, prv_s_r, nxt_s_r, ins_s_r;
  logic [ffha_pkg::OFF_W-1:0] nstart_r, gstart_r, rdq_s_r, urd_s_r, res_r, len_r;
  logic [ffha_pkg::SZ_W-1:0]  need_r, bsize_r, prv_z_r, nxt_z_r, ins_z_r, total_r;
  logic [ffha_pkg::SZ_W-1:0]  grant_r, origz_r, rdq_z_r, urd_z_r, avail_r, h_r;
  logic [ffha_pkg::CNT_W-1:0] p_r, fcnt_r, ucnt_r;
  logic [ffha_pkg::IDX_W-1:0] u_r, f_r;
  logic [1:0]                 stat_r;
  logic                       mv_r, ins_ok_r;

  logic                       out_valid_r, out_mv_r;
  logic [1:0]                 out_stat_r;
  logic [ffha_pkg::OFF_W-1:0] out_res_r, out_src_r, out_len_r;
  logic [ffha_pkg::SZ_W-1:0]  out_free_r;

  ffha_pkg::fcmd_t fcmd;
  ffha_pkg::ucmd_t ucmd;
  logic [ffha_pkg::OFF_W-1:0] key_addr;
  logic [ffha_pkg::IDX_W-1:0] rd_idx, urd_idx;

  logic [ffha_pkg::OFF_W-1:0] fs [NF];
  logic [ffha_pkg::SZ_W-1:0]  fz [NF];
  logic [ffha_pkg::OFF_W-1:0] lft_s [NF];
  logic [ffha_pkg::SZ_W-1:0]  lft_z [NF];
  logic [ffha_pkg::OFF_W-1:0] rgt_s [NF];
  logic [ffha_pkg::SZ_W-1:0]  rgt_z [NF];
  logic [NF-1:0] fit_v, le_v, fvalid;
  logic [ffha_pkg::OFF_W-1:0] us [NU];
  logic [ffha_pkg::SZ_W-1:0]  uz [NU];
  logic [NU-1:0] match_v, uvalid;

  // Free extent row
  for (genvar gi = 0; gi < NF; gi++) begin : g_free
    if (gi == 0) begin : g_first
      assign lft_s[gi] = '0;
      assign lft_z[gi] = '0;
    end else begin : g_mid
      assign lft_s[gi] = fs[gi-1];
      assign lft_z[gi] = fz[gi-1];
    end
    if (gi == NF - 1) begin : g_last
      assign rgt_s[gi] = fs[gi];
      assign rgt_z[gi] = fz[gi];
    end else begin : g_inner
      assign rgt_s[gi] = fs[gi+1];
      assign rgt_z[gi] = fz[gi+1];
    end
    assign fvalid[gi] = ffha_pkg::CNT_W'(gi) < fcnt_r;
    ffha_free_cell u_cell (
      .clk        (clk),
      .cell_idx   (ffha_pkg::IDX_W'(gi)),
      .cmd        (fcmd),
      .left_start (lft_s[gi]),
      .left_size  (lft_z[gi]),
      .right_start(rgt_s[gi]),
      .right_size (rgt_z[gi]),
      .key_addr   (key_addr),
      .key_size   (need_r),
      .start      (fs[gi]),
      .size       (fz[gi]),
      .fit        (fit_v[gi]),
      .le         (le_v[gi])
    );
  end

  // Allocated extent row
  for (genvar gu = 0; gu < NU; gu++) begin : g_used
    assign uvalid[gu] = ffha_pkg::CNT_W'(gu) < ucnt_r;
    ffha_used_cell u_cell (
      .clk     (clk),
      .cell_idx(ffha_pkg::IDX_W'(gu)),
      .cmd     (ucmd),
      .key_off (off_r),
      .start   (us[gu]),
      .size    (uz[gu]),
      .match   (match_v[gu])
    );
  end

  // Searches over the rows
  logic [ffha_pkg::CNT_W-1:0] p_find, fit_idx, u_idx;
  assign p_find  = ffha_pkg::first_set(~(fvalid & le_v));
  assign fit_idx = ffha_pkg::first_set(fvalid & fit_v);
  assign u_idx   = ffha_pkg::first_set(uvalid & match_v);

  // Neighbour and merge decisions
  logic [17:0] prv_end, ins_end, bend, grow_n_sum, grow_p_sum, grow_pn_sum;
  logic        pv_prev, pv_next, ins_padj, ins_both, ins_nadj, ra_nadj, ra_padj;
  logic [ffha_pkg::SZ_W-1:0] merged_z, diff, rem_n, rem_m, take_rem, app;

  assign prv_end  = 18'(prv_s_r) + 18'(prv_z_r);
  assign ins_end  = 18'(ins_s_r) + 18'(ins_z_r);
  assign bend     = 18'(bstart_r) + 18'(bsize_r);
  assign pv_prev  = p_r != '0;
  assign pv_next  = p_r < fcnt_r;
  assign merged_z = prv_z_r + ins_z_r;
  assign ins_padj = pv_prev && prv_end == 18'(ins_s_r);
  assign ins_both = pv_next && (18'(prv_s_r) + 18'(merged_z)) == 18'(nxt_s_r);
  assign ins_nadj = pv_next && ins_end == 18'(nxt_s_r);
  assign ra_nadj  = pv_next && 18'(nxt_s_r) == bend;
  assign ra_padj  = pv_prev && prv_end == 18'(bstart_r);
  assign grow_n_sum  = 18'(bsize_r) + 18'(nxt_z_r);
  assign grow_p_sum  = 18'(prv_z_r) + 18'(bsize_r);
  assign grow_pn_sum = grow_p_sum + 18'(nxt_z_r);
  assign diff     = bsize_r - need_r;
  assign rem_n    = ffha_pkg::SZ_W'(grow_n_sum) - need_r;
  assign rem_m    = total_r - need_r;
  assign take_rem = rdq_z_r - need_r;
  assign app      = bsize_r - ffha_pkg::HDR_BYTES;

  logic [ffha_pkg::SZ_W-1:0] hc;
  assign hc = (cfg_ch.heap_bytes > ffha_pkg::HEAP_CAP) ? ffha_pkg::HEAP_CAP : cfg_ch.heap_bytes;

  // Handshakes
  logic in_acc, cfg_acc;
  assign cfg_ch.ready = state_r == S_IDLE;
  assign in_ch.ready  = state_r == S_IDLE && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Row commands issued by the current step
  always_comb begin
    fcmd     = '{op: ffha_pkg::F_HOLD, idx: '0, start: '0, size: '0};
    ucmd     = '{we: 1'b0, idx: '0, start: '0, size: '0};
    key_addr = (state_r == S_RA_P) ? bstart_r : ins_s_r;
    rd_idx   = ffha_pkg::IDX_W'(p_r);
    urd_idx  = u_r;
    case (state_r)
      S_INIT: begin
        fcmd = '{op: ffha_pkg::F_WRITE, idx: '0, start: '0, size: h_r - ffha_pkg::HDR_BYTES};
      end
      S_NB_A: rd_idx = ffha_pkg::IDX_W'(p_r - 1'b1);
      S_TAKE_A: rd_idx = f_r;
      S_FREE_FIN: urd_idx = ffha_pkg::IDX_W'(ucnt_r - 1'b1);
      S_FREE_MV: ucmd = '{we: 1'b1, idx: u_r, start: urd_s_r, size: urd_z_r};
      S_INS_D: begin
        if (ins_padj) begin
          fcmd = '{op: ffha_pkg::F_WRITE, idx: ffha_pkg::IDX_W'(p_r - 1'b1), start: prv_s_r,
                   size: ins_both ? merged_z + nxt_z_r : merged_z};
        end else if (ins_nadj) begin
          fcmd = '{op: ffha_pkg::F_WRITE, idx: ffha_pkg::IDX_W'(p_r), start: ins_s_r,
                   size: nxt_z_r + ins_z_r};
        end else if (fcnt_r < ffha_pkg::CNT_W'(NF)) begin
          fcmd = '{op: ffha_pkg::F_INSERT, idx: ffha_pkg::IDX_W'(p_r), start: ins_s_r,
                   size: ins_z_r};
        end
      end
      S_INS_E, S_RA_M2: begin
        fcmd = '{op: ffha_pkg::F_REMOVE, idx: ffha_pkg::IDX_W'(state_r == S_RA_M2 ?
                 p_r - 1'b1 : p_r), start: '0, size: '0};
      end
      S_SHR_FIN, S_RA_M4: begin
        if (state_r == S_RA_M4 || ins_ok_r) begin
          ucmd = '{we: 1'b1, idx: u_r, start: (state_r == S_RA_M4) ? nstart_r : bstart_r,
                   size: need_r};
        end
      end
      S_RA_D: begin
        if (need_r < bsize_r) begin
          if (diff < ffha_pkg::HDR_BYTES && ra_nadj) begin
            fcmd = '{op: ffha_pkg::F_WRITE, idx: ffha_pkg::IDX_W'(p_r),
                     start: nxt_s_r - ffha_pkg::OFF_W'(diff), size: nxt_z_r + diff};
            ucmd = '{we: 1'b1, idx: u_r, start: bstart_r, size: need_r};
          end
        end else if (need_r != bsize_r) begin
          if (ra_nadj && grow_n_sum >= 18'(need_r)) begin
            if (rem_n >= ffha_pkg::HDR_BYTES) begin
              fcmd = '{op: ffha_pkg::F_WRITE, idx: ffha_pkg::IDX_W'(p_r),
                       start: bstart_r + ffha_pkg::OFF_W'(need_r), size: rem_n};
              ucmd = '{we: 1'b1, idx: u_r, start: bstart_r, size: need_r};
            end else begin
              fcmd = '{op: ffha_pkg::F_REMOVE, idx: ffha_pkg::IDX_W'(p_r), start: '0, size: '0};
              ucmd = '{we: 1'b1, idx: u_r, start: bstart_r,
                       size: ffha_pkg::SZ_W'(grow_n_sum)};
            end
          end else if (ra_padj && (grow_p_sum >= 18'(need_r) ||
                       (ra_nadj && grow_pn_sum >= 18'(need_r)))) begin
            fcmd = '{op: ffha_pkg::F_REMOVE, idx: ffha_pkg::IDX_W'(grow_p_sum >= 18'(need_r) ?
                     p_r - 1'b1 : p_r), start: '0, size: '0};
          end
        end
      end
      S_RA_M3: begin
        if (rem_m < ffha_pkg::HDR_BYTES) ucmd = '{we: 1'b1, idx: u_r, start: nstart_r,
                                                  size: total_r};
      end
      S_TAKE_B: begin
        if (take_rem >= ffha_pkg::HDR_BYTES) begin
          fcmd = '{op: ffha_pkg::F_WRITE, idx: f_r, start: rdq_s_r + ffha_pkg::OFF_W'(need_r),
                   size: take_rem};
        end else begin
          fcmd = '{op: ffha_pkg::F_REMOVE, idx: f_r, start: '0, size: '0};
        end
        if (kind_r == K_ALLOC) begin
          ucmd = '{we: 1'b1, idx: ffha_pkg::IDX_W'(ucnt_r), start: rdq_s_r,
                   size: (take_rem >= ffha_pkg::HDR_BYTES) ? need_r : rdq_z_r};
        end
      end
      S_FRESH_FIN: begin
        if (!ins_ok_r) begin
          fcmd = '{op: ffha_pkg::F_WRITE, idx: f_r, start: gstart_r, size: origz_r};
        end else begin
          ucmd = '{we: 1'b1, idx: u_r, start: gstart_r, size: grant_r};
        end
      end
      default: ;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    rdq_s_r <= fs[rd_idx];
    rdq_z_r <= fz[rd_idx];
    urd_s_r <= us[urd_idx];
    urd_z_r <= uz[urd_idx];
    if (!rst_n) begin
      state_r     <= S_INIT;
      h_r         <= ffha_pkg::HEAP_CAP;
      fcnt_r      <= '0;
      ucnt_r      <= '0;
      avail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          ucnt_r <= '0;
          if (h_r >= ffha_pkg::TWO_HDR) begin
            fcnt_r  <= ffha_pkg::CNT_W'(1);
            avail_r <= h_r - ffha_pkg::HDR_BYTES;
          end else begin
            fcnt_r  <= '0;
            avail_r <= '0;
          end
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_acc) begin
            h_r     <= hc & ~ffha_pkg::ALIGN_MASK;
            state_r <= S_INIT;
          end else if (in_acc) begin
            req_r   <= in_ch.request_bytes;
            off_r   <= in_ch.data_offset;
            need_r  <= ((ffha_pkg::SZ_W'(in_ch.request_bytes) + ffha_pkg::ALIGN_MASK) &
                        ~ffha_pkg::ALIGN_MASK) + ffha_pkg::HDR_BYTES;
            stat_r  <= ffha_pkg::ST_OK;
            res_r   <= '0;
            mv_r    <= 1'b0;
            len_r   <= '0;
            kind_r  <= (in_ch.op == ffha_pkg::OP_ALLOC) ? K_ALLOC :
                       (in_ch.op == ffha_pkg::OP_FREE) ? K_FREE : K_REALLOC;
            state_r <= (in_ch.op == ffha_pkg::OP_ALLOC || in_ch.op == ffha_pkg::OP_FREE ||
                        in_ch.op == ffha_pkg::OP_REALLOC) ? S_DISP : S_DONE;
            if (!(in_ch.op == ffha_pkg::OP_ALLOC || in_ch.op == ffha_pkg::OP_FREE ||
                  in_ch.op == ffha_pkg::OP_REALLOC)) stat_r <= ffha_pkg::ST_INVAL;
          end
        end
        S_DISP: begin
          if (kind_r == K_FREE || (kind_r == K_REALLOC && req_r == '0)) begin
            kind_r  <= K_FREE;
            state_r <= (off_r == '0) ? S_DONE : S_FIND;
          end else if (kind_r == K_REALLOC && off_r != '0) begin
            state_r <= S_FIND;
          end else begin
            kind_r <= K_ALLOC;
            if (req_r == '0) begin
              stat_r  <= ffha_pkg::ST_INVAL;
              state_r <= S_DONE;
            end else if (ucnt_r >= ffha_pkg::CNT_W'(NU)) begin
              stat_r  <= ffha_pkg::ST_FULL;
              state_r <= S_DONE;
            end else begin
              state_r <= S_TAKE_F;
            end
          end
        end
        S_FIND: begin
          if (u_idx[ffha_pkg::CNT_W-1]) begin
            stat_r  <= ffha_pkg::ST_INVAL;
            state_r <= S_DONE;
          end else begin
            u_r     <= u_idx[ffha_pkg::IDX_W-1:0];
            state_r <= S_URD_A;
          end
        end
        S_URD_A: state_r <= S_URD_B;
        S_URD_B: begin
          bstart_r <= urd_s_r;
          bsize_r  <= urd_z_r;
          ins_s_r  <= urd_s_r;
          ins_z_r  <= urd_z_r;
          ins_ret_r <= S_FREE_FIN;
          state_r  <= (kind_r == K_FREE) ? S_INS_P : S_RA_P;
        end
        // Fetch the free neighbours below and above position p
        S_NB_A: state_r <= S_NB_B;
        S_NB_B: begin
          prv_s_r <= rdq_s_r;
          prv_z_r <= rdq_z_r;
          state_r <= S_NB_C;
        end
        S_NB_C: begin
          nxt_s_r <= rdq_s_r;
          nxt_z_r <= rdq_z_r;
          state_r <= nb_ret_r;
        end
        S_INS_P: begin
          p_r      <= p_find;
          nb_ret_r <= S_INS_D;
          state_r  <= S_NB_A;
        end
        S_INS_D: begin
          if (ins_padj && ins_both) begin
            state_r <= S_INS_E;
          end else begin
            ins_ok_r <= ins_padj || ins_nadj || fcnt_r < ffha_pkg::CNT_W'(NF);
            if (!ins_padj && !ins_nadj && fcnt_r < ffha_pkg::CNT_W'(NF)) fcnt_r <= fcnt_r + 1'b1;
            state_r <= ins_ret_r;
          end
        end
        S_INS_E: begin
          fcnt_r   <= fcnt_r - 1'b1;
          ins_ok_r <= 1'b1;
          state_r  <= ins_ret_r;
        end
        S_FREE_FIN: begin
          if (!ins_ok_r) begin
            stat_r  <= ffha_pkg::ST_FULL;
            state_r <= S_DONE;
          end else begin
            avail_r <= avail_r + bsize_r;
            state_r <= S_FREE_MV;
          end
        end
        S_FREE_MV: begin
          ucnt_r  <= ucnt_r - 1'b1;
          state_r <= S_DONE;
        end
        S_RA_P: begin
          p_r      <= p_find;
          nb_ret_r <= S_RA_D;
          state_r  <= S_NB_A;
        end
        S_RA_D: begin
          state_r <= S_DONE;
          res_r   <= off_r;
          if (need_r < bsize_r) begin
            if (diff >= ffha_pkg::HDR_BYTES) begin
              ins_s_r   <= bstart_r + ffha_pkg::OFF_W'(need_r);
              ins_z_r   <= diff;
              ins_ret_r <= S_SHR_FIN;
              state_r   <= S_INS_P;
            end else if (ra_nadj) begin
              avail_r <= avail_r + diff;
            end
          end else if (need_r != bsize_r) begin
            if (ra_nadj && grow_n_sum >= 18'(need_r)) begin
              if (rem_n >= ffha_pkg::HDR_BYTES) begin
                avail_r <= avail_r - nxt_z_r + rem_n;
              end else begin
                avail_r <= avail_r - nxt_z_r;
                fcnt_r  <= fcnt_r - 1'b1;
              end
            end else if (ra_padj && (grow_p_sum >= 18'(need_r) ||
                         (ra_nadj && grow_pn_sum >= 18'(need_r)))) begin
              nstart_r <= prv_s_r;
              fcnt_r   <= fcnt_r - 1'b1;
              if (grow_p_sum >= 18'(need_r)) begin
                total_r <= ffha_pkg::SZ_W'(grow_p_sum);
                avail_r <= avail_r - prv_z_r;
                state_r <= S_RA_M3;
              end else begin
                total_r <= ffha_pkg::SZ_W'(grow_pn_sum);
                avail_r <= avail_r - prv_z_r - nxt_z_r;
                state_r <= S_RA_M2;
              end
            end else begin
              res_r   <= '0;
              state_r <= S_TAKE_F;
            end
          end
        end
        S_RA_M2: begin
          fcnt_r  <= fcnt_r - 1'b1;
          state_r <= S_RA_M3;
        end
        S_RA_M3: begin
          if (rem_m >= ffha_pkg::HDR_BYTES) begin
            ins_s_r   <= nstart_r + ffha_pkg::OFF_W'(need_r);
            ins_z_r   <= rem_m;
            ins_ret_r <= S_RA_M4;
            state_r   <= S_INS_P;
          end else begin
            res_r   <= nstart_r + ffha_pkg::OFF_W'(ffha_pkg::HDR_BYTES);
            mv_r    <= 1'b1;
            len_r   <= ffha_pkg::OFF_W'(app);
            state_r <= S_DONE;
          end
        end
        S_RA_M4: begin
          avail_r <= avail_r + rem_m;
          res_r   <= nstart_r + ffha_pkg::OFF_W'(ffha_pkg::HDR_BYTES);
          mv_r    <= 1'b1;
          len_r   <= ffha_pkg::OFF_W'(app);
          state_r <= S_DONE;
        end
        S_SHR_FIN: begin
          if (!ins_ok_r) begin
            stat_r <= ffha_pkg::ST_FULL;
            res_r  <= '0;
          end else begin
            avail_r <= avail_r + diff;
          end
          state_r <= S_DONE;
        end
        // First fit over the free row
        S_TAKE_F: begin
          if (fit_idx[ffha_pkg::CNT_W-1]) begin
            stat_r  <= ffha_pkg::ST_NOMEM;
            state_r <= S_DONE;
          end else begin
            f_r     <= fit_idx[ffha_pkg::IDX_W-1:0];
            state_r <= S_TAKE_A;
          end
        end
        S_TAKE_A: state_r <= S_TAKE_B;
        S_TAKE_B: begin
          gstart_r <= rdq_s_r;
          origz_r  <= rdq_z_r;
          if (take_rem >= ffha_pkg::HDR_BYTES) begin
            grant_r <= need_r;
            avail_r <= avail_r - need_r;
          end else begin
            grant_r <= rdq_z_r;
            avail_r <= avail_r - rdq_z_r;
            fcnt_r  <= fcnt_r - 1'b1;
          end
          if (kind_r == K_ALLOC) begin
            ucnt_r  <= ucnt_r + 1'b1;
            res_r   <= rdq_s_r + ffha_pkg::OFF_W'(ffha_pkg::HDR_BYTES);
            state_r <= S_DONE;
          end else begin
            ins_s_r   <= bstart_r;
            ins_z_r   <= bsize_r;
            ins_ret_r <= S_FRESH_FIN;
            state_r   <= S_INS_P;
          end
        end
        S_FRESH_FIN: begin
          if (!ins_ok_r) begin
            avail_r <= avail_r + grant_r;
            stat_r  <= ffha_pkg::ST_FULL;
          end else begin
            avail_r <= avail_r + bsize_r;
            res_r   <= gstart_r + ffha_pkg::OFF_W'(ffha_pkg::HDR_BYTES);
            mv_r    <= 1'b1;
            len_r   <= (ffha_pkg::SZ_W'(req_r) < app) ? req_r : ffha_pkg::OFF_W'(app);
          end
          state_r <= S_DONE;
        end
        // Hand the result over once the output register is free
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= stat_r;
            out_res_r   <= res_r;
            out_mv_r    <= mv_r;
            out_src_r   <= mv_r ? off_r : '0;
            out_len_r   <= mv_r ? len_r : '0;
            out_free_r  <= avail_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_stat_r;
  assign out_ch.result_offset = out_res_r;
  assign out_ch.move_needed   = out_mv_r;
  assign out_ch.move_source   = out_src_r;
  assign out_ch.move_length   = out_len_r;
  assign out_ch.free_bytes    = out_free_r;

endmodule
`default_nettype wire

/* hw/rtl/ffha_checker.sv */
// Port-level checks of the heap allocator and their binding to the top level.
`default_nettype none
module ffha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] result_offset,
  input wire logic        move_needed,
  input wire logic [16:0] free_bytes
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_offset) && $stable(status))
    else $error("stalled result changed");

  // Busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("took an item while busy");

  // Free total never exceeds the largest heap minus the end mark
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> free_bytes <= 17'd65528)
    else $error("free total out of range");

  // A move always comes with a successful result offset
  a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && move_needed |-> status == ffha_pkg::ST_OK && result_offset != 16'd0)
    else $error("move without a valid result");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .result_offset(out_ch.result_offset),
  .move_needed  (out_ch.move_needed),
  .free_bytes   (out_ch.free_bytes)
);
`default_nettype wire

/* bench/ffha_bench_pkg.sv */
// Behavioural heap allocator used to predict the block's results.
`default_nettype none
package ffha_bench_pkg;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_offset;
    logic        move_needed;
    logic [15:0] move_source;
    logic [15:0] move_length;
    logic [16:0] free_bytes;
  } heap_result_t;

  class heap_shadow;
    int unsigned fs[ffha_pkg::NFREE];
    int unsigned fz[ffha_pkg::NFREE];
    int unsigned fcnt;
    int unsigned us[ffha_pkg::NUSED];
    int unsigned uz[ffha_pkg::NUSED];
    int unsigned ucnt;
    int unsigned avail;
    int unsigned heap;

    function void reinit(int unsigned value);
      int unsigned h;
      h = value & 32'h1FFFF;
      if (h > 65536) h = 65536;
      h = h - (h % 4);
      heap = h;
      foreach (fs[i]) begin
        fs[i] = 0;
        fz[i] = 0;
        us[i] = 0;
        uz[i] = 0;
      end
      fcnt = 0;
      ucnt = 0;
      avail = 0;
      if (h >= 16) begin
        fz[0] = h - 8;
        fcnt = 1;
        avail = h - 8;
      end
    endfunction

    function int unsigned round4(int unsigned x);
      return ((x + 3) / 4) * 4;
    endfunction

    function void drop_free(int unsigned i);
      for (int unsigned k = i; k + 1 < fcnt; k++) begin
        fs[k] = fs[k+1];
        fz[k] = fz[k+1];
      end
      fcnt--;
    endfunction

    function int unsigned above(int unsigned addr);
      int unsigned p;
      p = 0;
      while (p < fcnt && fs[p] <= addr) p++;
      return p;
    endfunction

    // Insert an extent with merging; 0 when a slot was needed and none is left
    function bit put_free(int unsigned start, int unsigned size);
      int unsigned p;
      p = above(start);
      if (p > 0 && fs[p-1] + fz[p-1] == start) begin
        fz[p-1] += size;
        if (p < fcnt && fs[p-1] + fz[p-1] == fs[p]) begin
          fz[p-1] += fz[p];
          drop_free(p);
        end
        return 1;
      end
      if (p < fcnt && start + size == fs[p]) begin
        fs[p] = start;
        fz[p] += size;
        return 1;
      end
      if (fcnt >= ffha_pkg::NFREE) return 0;
      for (int unsigned k = fcnt; k > p; k--) begin
        fs[k] = fs[k-1];
        fz[k] = fz[k-1];
      end
      fs[p] = start;
      fz[p] = size;
      fcnt++;
      return 1;
    endfunction

    function int unsigned take_first(int unsigned need, output int unsigned start);
      int unsigned g;
      start = 0;
      for (int unsigned i = 0; i < fcnt; i++) begin
        if (fz[i] >= need) begin
          start = fs[i];
          if (fz[i] - need >= 8) begin
            fs[i] += need;
            fz[i] -= need;
            g = need;
          end else begin
            g = fz[i];
            drop_free(i);
          end
          avail -= g;
          return g;
        end
      end
      return 0;
    endfunction

    function bit find_used(int unsigned off, output int unsigned idx);
      idx = 0;
      for (int unsigned k = 0; k < ucnt; k++) begin
        if (us[k] + 8 == off) begin
          idx = k;
          return 1;
        end
      end
      return 0;
    endfunction

    function logic [1:0] alloc(int unsigned req, output int unsigned res);
      int unsigned st, g;
      res = 0;
      if (req == 0) return ffha_pkg::ST_INVAL;
      if (ucnt >= ffha_pkg::NUSED) return ffha_pkg::ST_FULL;
      g = take_first(round4(req) + 8, st);
      if (g == 0) return ffha_pkg::ST_NOMEM;
      us[ucnt] = st;
      uz[ucnt] = g;
      ucnt++;
      res = st + 8;
      return ffha_pkg::ST_OK;
    endfunction

    function logic [1:0] release_off(int unsigned off);
      int unsigned u, last;
      if (off == 0) return ffha_pkg::ST_OK;
      if (!find_used(off, u)) return ffha_pkg::ST_INVAL;
      if (!put_free(us[u], uz[u])) return ffha_pkg::ST_FULL;
      avail += uz[u];
      last = ucnt - 1;
      us[u] = us[last];
      uz[u] = uz[last];
      ucnt = last;
      return ffha_pkg::ST_OK;
    endfunction

    function logic [1:0] resize(int unsigned req, int unsigned off, output int unsigned res,
                                output int unsigned mv, output int unsigned src,
                                output int unsigned len);
      int unsigned u, bs, bz, be, need, p, diff, total, ns, g, gs, app;
      bit nadj, padj;
      int unsigned sfs[ffha_pkg::NFREE], sfz[ffha_pkg::NFREE], sfc, sav;
      res = 0; mv = 0; src = 0; len = 0;
      if (req == 0) return release_off(off);
      if (off == 0) return alloc(req, res);
      if (!find_used(off, u)) return ffha_pkg::ST_INVAL;
      bs = us[u];
      bz = uz[u];
      be = bs + bz;
      need = round4(req) + 8;
      p = above(bs);
      if (need == bz) begin
        res = off;
        return ffha_pkg::ST_OK;
      end
      // Shrink in place
      if (need < bz) begin
        diff = bz - need;
        if (diff >= 8) begin
          if (!put_free(bs + need, diff)) return ffha_pkg::ST_FULL;
          avail += diff;
          uz[u] = need;
        end else if (p < fcnt && fs[p] == be) begin
          fs[p] -= diff;
          fz[p] += diff;
          avail += diff;
          uz[u] = need;
        end
        res = off;
        return ffha_pkg::ST_OK;
      end
      nadj = p < fcnt && fs[p] == be;
      padj = p > 0 && fs[p-1] + fz[p-1] == bs;
      app = bz - 8;
      // Grow into the free extent above
      if (nadj && bz + fz[p] >= need) begin
        total = bz + fz[p];
        avail -= fz[p];
        if (total - need >= 8) begin
          fs[p] = bs + need;
          fz[p] = total - need;
          avail += total - need;
          uz[u] = need;
        end else begin
          drop_free(p);
          uz[u] = total;
        end
        res = off;
        return ffha_pkg::ST_OK;
      end
      // Slide down into the free extent below
      if (padj && (fz[p-1] + bz >= need || (nadj && fz[p-1] + bz + fz[p] >= need))) begin
        ns = fs[p-1];
        total = fz[p-1] + bz;
        avail -= fz[p-1];
        if (total < need) begin
          total += fz[p];
          avail -= fz[p];
          drop_free(p);
        end
        drop_free(p - 1);
        us[u] = ns;
        if (total - need >= 8) begin
          void'(put_free(ns + need, total - need));
          avail += total - need;
          uz[u] = need;
        end else begin
          uz[u] = total;
        end
        res = ns + 8;
        mv = 1;
        src = off;
        len = app;
        return ffha_pkg::ST_OK;
      end
      // Fresh allocation elsewhere; restore on a full table
      sfs = fs; sfz = fz; sfc = fcnt; sav = avail;
      g = take_first(need, gs);
      if (g == 0) return ffha_pkg::ST_NOMEM;
      if (!put_free(bs, bz)) begin
        fs = sfs; fz = sfz; fcnt = sfc; avail = sav;
        return ffha_pkg::ST_FULL;
      end
      avail += bz;
      us[u] = gs;
      uz[u] = g;
      res = gs + 8;
      mv = 1;
      src = off;
      len = req < app ? req : app;
      return ffha_pkg::ST_OK;
    endfunction

    function heap_result_t step(logic [1:0] op, int unsigned req, int unsigned off);
      heap_result_t r;
      int unsigned res, mv, src, len;
      res = 0; mv = 0; src = 0; len = 0;
      case (op)
        ffha_pkg::OP_ALLOC:   r.status = alloc(req, res);
        ffha_pkg::OP_FREE:    r.status = release_off(off);
        ffha_pkg::OP_REALLOC: r.status = resize(req, off, res, mv, src, len);
        default:              r.status = ffha_pkg::ST_INVAL;
      endcase
      r.result_offset = res[15:0];
      r.move_needed = mv[0];
      r.move_source = src[15:0];
      r.move_length = len[15:0];
      r.free_bytes = avail[16:0];
      return r;
    endfunction
  endclass
endpackage
`default_nettype wire

/* bench/tb_first_fit_heap_allocator.sv */
// Self-checking testbench of the first-fit heap allocator.
`default_nettype none
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [1:0] OP_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ffha_in_if  in_ch();
  ffha_out_if out_ch();
  ffha_cfg_if cfg_ch();

  first_fit_heap_allocator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  typedef struct {
    logic [1:0]                  op;
    logic [15:0]                 req;
    logic [15:0]                 off;
    bit                          typed;
    ffha_bench_pkg::heap_result_t want;
  } stim_row_t;

  ffha_bench_pkg::heap_shadow   shadow;
  ffha_bench_pkg::heap_result_t pending_results[$];
  ffha_bench_pkg::heap_result_t typed_results[$];
  bit           typed_flags[$];
  int unsigned  live_offsets[$];
  int           n_errors = 0;
  int           sender_idle = 0;
  int           receiver_stall = 0;
  longint       cycle_count = 0;

  // Stop the run at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random, check each accepted item
  always @(posedge clk) begin
    ffha_bench_pkg::heap_result_t got, want;
    bit typed;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.result_offset, out_ch.move_needed, out_ch.move_source,
                out_ch.move_length, out_ch.free_bytes};
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          typed = typed_flags.pop_front();
          if (typed) want = typed_results.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); n_errors++;
          end
          if (got.result_offset !== want.result_offset) begin
            $error("result_offset exp %0d got %0d", want.result_offset, got.result_offset);
            n_errors++;
          end
          if (got.move_needed !== want.move_needed) begin
            $error("move_needed exp %0d got %0d", want.move_needed, got.move_needed);
            n_errors++;
          end
          if (got.move_source !== want.move_source) begin
            $error("move_source exp %0d got %0d", want.move_source, got.move_source);
            n_errors++;
          end
          if (got.move_length !== want.move_length) begin
            $error("move_length exp %0d got %0d", want.move_length, got.move_length);
            n_errors++;
          end
          if (got.free_bytes !== want.free_bytes) begin
            $error("free_bytes exp %0d got %0d", want.free_bytes, got.free_bytes);
            n_errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  // Drive one request item, predict it, and hold until accepted
  task automatic send_item(logic [1:0] op, logic [15:0] req, logic [15:0] off,
                           bit typed, ffha_bench_pkg::heap_result_t want);
    ffha_bench_pkg::heap_result_t r;
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.request_bytes <= req;
    in_ch.data_offset <= off;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = shadow.step(op, req, off);
    if (op != OP_BAD && r.status == ffha_pkg::ST_OK) begin
      if (op == ffha_pkg::OP_FREE || (op == ffha_pkg::OP_REALLOC && req == 0)) begin
        foreach (live_offsets[i]) if (live_offsets[i] == off) begin
          live_offsets.delete(i);
          break;
        end
      end else if (op == ffha_pkg::OP_REALLOC && off != 0) begin
        foreach (live_offsets[i]) if (live_offsets[i] == off) live_offsets[i] = r.result_offset;
      end else if (r.result_offset != 0) begin
        live_offsets.push_back(r.result_offset);
      end
    end
    pending_results.push_back(r);
    typed_flags.push_back(typed);
    if (typed) typed_results.push_back(want);
  endtask

  // Drop the request, wait until every result is in, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_heap(logic [16:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.heap_bytes <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    shadow.reinit(value);
    live_offsets.delete();
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return 16'($urandom_range(1, 64));
    if (k < 92) return 16'($urandom_range(1, 1024));
    return 16'($urandom);
  endfunction

  // Random traffic: allocations and operations on live allocations, some noise
  task automatic random_phase(int count);
    int unsigned k;
    logic [15:0] off;
    ffha_bench_pkg::heap_result_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      off = live_offsets.size() ? 16'(live_offsets[$urandom_range(live_offsets.size() - 1)])
                                : 16'd0;
      if (k < 45) send_item(ffha_pkg::OP_ALLOC, pick_size(), 16'($urandom), 0, none);
      else if (k < 70) send_item(ffha_pkg::OP_FREE, 16'($urandom), off, 0, none);
      else if (k < 90) send_item(ffha_pkg::OP_REALLOC, pick_size(), off, 0, none);
      else if (k < 93) send_item(ffha_pkg::OP_REALLOC, 16'd0, off, 0, none);
      else if (k < 98) send_item(2'($urandom_range(1, 2)), pick_size(), 16'($urandom), 0, none);
      else send_item(OP_BAD, 16'($urandom), 16'($urandom), 0, none);
    end
  endtask

  stim_row_t directed_rows[$];

  function automatic ffha_bench_pkg::heap_result_t typed_res(logic [1:0] s, logic [15:0] r,
                                                             logic [16:0] f);
    ffha_bench_pkg::heap_result_t x;
    x = '0;
    x.status = s;
    x.result_offset = r;
    x.free_bytes = f;
    return x;
  endfunction

  initial begin
    ffha_bench_pkg::heap_result_t none;
    none = '0;
    shadow = new();
    shadow.reinit(65536);
    in_ch.valid = 1'b0;
    in_ch.op = ffha_pkg::OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.data_offset = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.heap_bytes = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: expectations typed only where obvious
    directed_rows = '{
      '{ffha_pkg::OP_ALLOC,   16'd0,    16'd0,    1,
        typed_res(ffha_pkg::ST_INVAL, 0, 17'd65528)},
      '{ffha_pkg::OP_FREE,    16'd0,    16'd0,    1,
        typed_res(ffha_pkg::ST_OK, 0, 17'd65528)},
      '{ffha_pkg::OP_REALLOC, 16'd0,    16'd0,    1,
        typed_res(ffha_pkg::ST_OK, 0, 17'd65528)},
      '{ffha_pkg::OP_FREE,    16'd0,    16'd4444, 1,
        typed_res(ffha_pkg::ST_INVAL, 0, 17'd65528)},
      '{OP_BAD,               16'hFFFF, 16'hFFFF, 1,
        typed_res(ffha_pkg::ST_INVAL, 0, 17'd65528)},
      '{ffha_pkg::OP_ALLOC,   16'd1,    16'd0,    1,
        typed_res(ffha_pkg::ST_OK, 16'd8, 17'd65516)},
      '{ffha_pkg::OP_ALLOC,   16'd13,   16'd0,    0, none},
      '{ffha_pkg::OP_ALLOC,   16'd100,  16'd0,    0, none},
      '{ffha_pkg::OP_REALLOC, 16'd4,    16'd8,    0, none},
      '{ffha_pkg::OP_REALLOC, 16'd40,   16'd28,   0, none},
      '{ffha_pkg::OP_FREE,    16'd0,    16'd8,    0, none},
      '{ffha_pkg::OP_REALLOC, 16'd60,   16'd48,   0, none},
      '{ffha_pkg::OP_REALLOC, 16'd8,    16'd28,   0, none},
      '{ffha_pkg::OP_ALLOC,   16'hFFFF, 16'd0,    1,
        typed_res(ffha_pkg::ST_NOMEM, 0, 17'd0)},
      '{ffha_pkg::OP_REALLOC, 16'd3000, 16'd0,    0, none},
      '{ffha_pkg::OP_REALLOC, 16'hFFFF, 16'd28,   0, none},
      '{ffha_pkg::OP_REALLOC, 16'd0,    16'd28,   0, none},
      '{ffha_pkg::OP_REALLOC, 16'd5,    16'hFFFF, 0, none}
    };
    foreach (directed_rows[i]) begin
      // The full-heap row's free count is whatever is left, so predict it
      if (directed_rows[i].op == ffha_pkg::OP_ALLOC && directed_rows[i].req == 16'hFFFF)
        directed_rows[i].want.free_bytes = shadow.avail[16:0];
      send_item(directed_rows[i].op, directed_rows[i].req, directed_rows[i].off,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // Tiny heaps: one too small for any extent and one with room for a single allocation
    write_heap(17'd12);
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 16'd0, 1, typed_res(ffha_pkg::ST_NOMEM, 0, 17'd0));
    write_heap(17'd33);
    send_item(ffha_pkg::OP_ALLOC, 16'd16, 16'd0, 1, typed_res(ffha_pkg::ST_OK, 16'd8, 17'd0));
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 16'd0, 1, typed_res(ffha_pkg::ST_NOMEM, 0, 17'd0));

    // Fill the tables with small extents, then free alternate ones
    write_heap(17'd65536);
    for (int i = 0; i < 66; i++) send_item(ffha_pkg::OP_ALLOC, 16'd4, 16'd0, 0, none);
    for (int i = 0; i < 64; i += 2) send_item(ffha_pkg::OP_FREE, 16'd0, 16'(8 + i * 12), 0, none);
    send_item(ffha_pkg::OP_FREE, 16'd0, 16'(8 + 63 * 12), 0, none);
    send_item(ffha_pkg::OP_REALLOC, 16'd1, 16'(8 + 61 * 12), 0, none);
    send_item(ffha_pkg::OP_REALLOC, 16'd100, 16'(8 + 59 * 12), 0, none);

    // Random phases over several heap sizes and idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin sender_idle = 0;  receiver_stall = 0;  write_heap(17'd65536); end
        1: begin sender_idle = 74; receiver_stall = 0;  write_heap(17'd32);    end
        2: begin sender_idle = 0;  receiver_stall = 74; write_heap(17'd2048);  end
        3: begin sender_idle = 27; receiver_stall = 27; write_heap(17'h1FFFF); end
        default: begin sender_idle = 0; receiver_stall = 0; write_heap(17'd700); end
      endcase
      random_phase(ph == 1 ? 60 : 250);
    end

    drain();
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
